/* hw/rtl/active_expired_priority_scheduler_macros.svh */
// assertion macros for the active/expired priority scheduler
`ifndef ACTIVE_EXPIRED_PRIORITY_SCHEDULER_MACROS_SVH
`define ACTIVE_EXPIRED_PRIORITY_SCHEDULER_MACROS_SVH

// same-cycle implication, checked on the rising clock, off during reset
`define AEPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock, off during reset
`define AEPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/aeps_pkg.sv */
// shared constants and types of the active/expired priority scheduler
`timescale 1ns / 1ps
`default_nettype none

package aeps_pkg;

   // levels per bank and ids per level fifo (both powers of two)
   localparam int MAX_LEVELS  = 16;
   localparam int QUEUE_DEPTH = 16;

   localparam int LEVEL_W     = $clog2(MAX_LEVELS);
   localparam int QIDX_W      = LEVEL_W + 1;
   localparam int NUM_QUEUES  = 2 * MAX_LEVELS;
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_AW    = QIDX_W + SLOT_W;
   localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ID_W        = 8;
   localparam int CFG_W       = 5;
   localparam logic [CFG_W-1:0] NUM_LEVELS_RESET = CFG_W'(4);

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // one pointer table entry: fifo read pointer and fill count
   typedef struct packed {
      logic [SLOT_W-1:0]  head;
      logic [COUNT_W-1:0] count;
   } ptr_entry_type;

   // pointer table write port
   typedef struct packed {
      logic              en;
      logic [QIDX_W-1:0] addr;
      ptr_entry_type     data;
   } ptr_wr_type;

   // id store write port
   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [ID_W-1:0]     data;
   } store_wr_type;

endpackage

`default_nettype wire

/* hw/rtl/active_expired_priority_scheduler.sv */
// top level of the active/expired multilevel priority scheduler
//
// Two banks of 16 per-level fifos (16 ids each), one active and one expired.
// An item is taken when start is high and busy is low; each item gives one
// result, shown for a single cycle with rsp_valid high, and the receiver
// cannot stall it. From accept to the next possible accept: a rejected add
// (level out of range) or a get that finds nothing stays in idle, an add does
// a pointer table read, then the id and pointer write, and a get a pointer
// table read, then an id store read. The result strobe comes in the cycle
// after the last of these. Emptiness and the highest occupied level come from
// a per-queue occupancy vector kept next to the pointer table. num_levels must
// be written through csr_we / csr_wdata while idle, not enforced by the block.
`timescale 1ns / 1ps
`default_nettype none

`include "active_expired_priority_scheduler_macros.svh"

module active_expired_priority_scheduler (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_we,
   input  wire logic [aeps_pkg::CFG_W-1:0]  csr_wdata,
   // request
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_mode,
   input  wire logic [aeps_pkg::ID_W-1:0]   req_proc_id,
   input  wire logic signed [4:0]           req_dyn_prio,
   input  wire logic [4:0]                  req_static_prio,
   // result
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [aeps_pkg::ID_W-1:0]        rsp_proc_id,
   output logic [3:0]                       rsp_level,
   output logic                             rsp_to_expired,
   output logic                             rsp_banks_swapped
);
   import aeps_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_PTR  = 3'b010,
      S_POP  = 3'b100
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic                   act_ff, act_in;
   logic [CFG_W-1:0]       num_levels_ff, num_levels_in;
   logic [NUM_QUEUES-1:0]  ne_ff, ne_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // request held across stages
   logic                   mode_ff, mode_in;
   logic [ID_W-1:0]        pid_ff, pid_in;
   logic [QIDX_W-1:0]      q_ff, q_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic                   exp_ff, exp_in;
   logic                   swap_ff, swap_in;

   // result registers
   status_type             rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]        rsp_pid_ff, rsp_pid_in;
   logic [LEVEL_W-1:0]     rsp_level_ff, rsp_level_in;
   logic                   rsp_exp_ff, rsp_exp_in;
   logic                   rsp_swap_ff, rsp_swap_in;

   // memory ports
   logic                   ptr_rd_en;
   logic [QIDX_W-1:0]      ptr_rd_addr;
   ptr_entry_type          ptr_rd;
   ptr_wr_type             ptr_wr;
   logic                   st_rd_en;
   logic [STORE_AW-1:0]    st_rd_addr;
   logic [ID_W-1:0]        st_rd;
   store_wr_type           st_wr;

   // decode of the incoming item
   logic                   accept;
   logic [CFG_W-1:0]       n_lvls;
   logic [MAX_LEVELS-1:0]  lvl_mask;
   logic signed [5:0]      add_level_s;
   logic                   add_exp;
   logic                   add_bank;
   logic                   add_in_range;
   logic [MAX_LEVELS-1:0]  act_vec;
   logic [MAX_LEVELS-1:0]  oth_vec;
   logic                   get_swap;
   logic [MAX_LEVELS-1:0]  pop_vec;
   logic [LEVEL_W-1:0]     pop_level;
   logic                   pop_found;
   logic                   pop_bank;
   logic                   full;
   logic [SLOT_W-1:0]      tail_slot;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // levels in use, clipped to the bank size
   assign n_lvls = (num_levels_ff > CFG_W'(MAX_LEVELS)) ? CFG_W'(MAX_LEVELS) : num_levels_ff;

   always_comb begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
         lvl_mask[i] = (CFG_W'(i) < n_lvls);
      end
   end

   // add target: expired bank at static-1 when dynamic priority is -1
   always_comb begin
      add_exp = (req_dyn_prio == -5'sd1);
      if (add_exp) begin
         add_level_s = $signed({1'b0, req_static_prio}) - 6'sd1;
         add_bank    = ~act_ff;
      end else begin
         add_level_s = 6'(req_dyn_prio);
         add_bank    = act_ff;
      end
      add_in_range = !add_level_s[5] && (add_level_s[4:0] < n_lvls);
   end

   // get: bank swap test and highest occupied level
   always_comb begin
      act_vec  = (act_ff ? ne_ff[NUM_QUEUES-1:MAX_LEVELS] : ne_ff[MAX_LEVELS-1:0]) & lvl_mask;
      oth_vec  = (act_ff ? ne_ff[MAX_LEVELS-1:0] : ne_ff[NUM_QUEUES-1:MAX_LEVELS]) & lvl_mask;
      get_swap = (act_vec == '0) && (oth_vec != '0);
      pop_vec  = get_swap ? oth_vec : act_vec;
      pop_bank = get_swap ? ~act_ff : act_ff;
      pop_found = (pop_vec != '0);
      pop_level = '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if (pop_vec[i]) begin
            pop_level = LEVEL_W'(i);
         end
      end
   end

   // pointer stage values
   assign full      = (ptr_rd.count >= COUNT_W'(QUEUE_DEPTH));
   assign tail_slot = ptr_rd.head + ptr_rd.count[SLOT_W-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      num_levels_in = num_levels_ff;
      ne_in         = ne_ff;
      rsp_valid_in  = 1'b0;
      mode_in       = mode_ff;
      pid_in        = pid_ff;
      q_in          = q_ff;
      level_in      = level_ff;
      exp_in        = exp_ff;
      swap_in       = swap_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_swap_in   = rsp_swap_ff;
      ptr_rd_en     = 1'b0;
      ptr_rd_addr   = '0;
      ptr_wr        = '0;
      st_rd_en      = 1'b0;
      st_rd_addr    = '0;
      st_wr         = '0;

      if (csr_we) begin
         num_levels_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               pid_in  = req_proc_id;
               if (!req_mode) begin
                  // add: reject out of range at once, else read pointers
                  q_in     = {add_bank, add_level_s[LEVEL_W-1:0]};
                  level_in = add_level_s[LEVEL_W-1:0];
                  exp_in   = add_exp;
                  swap_in  = 1'b0;
                  if (add_in_range) begin
                     ptr_rd_en   = 1'b1;
                     ptr_rd_addr = {add_bank, add_level_s[LEVEL_W-1:0]};
                     state_in    = S_PTR;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_RANGE;
                     rsp_pid_in    = req_proc_id;
                     rsp_level_in  = '0;
                     rsp_exp_in    = 1'b0;
                     rsp_swap_in   = 1'b0;
                  end
               end else begin
                  // get: swap banks if needed, then read the chosen queue
                  q_in     = {pop_bank, pop_level};
                  level_in = pop_level;
                  exp_in   = 1'b0;
                  swap_in  = get_swap;
                  if (get_swap) begin
                     act_in = ~act_ff;
                  end
                  if (pop_found) begin
                     ptr_rd_en   = 1'b1;
                     ptr_rd_addr = {pop_bank, pop_level};
                     state_in    = S_PTR;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EMPTY;
                     rsp_pid_in    = '0;
                     rsp_level_in  = '0;
                     rsp_exp_in    = 1'b0;
                     rsp_swap_in   = 1'b0;
                  end
               end
            end
         end
         S_PTR: begin
            if (!mode_ff) begin
               // add: append at tail unless the level is full
               rsp_valid_in = 1'b1;
               rsp_pid_in   = pid_ff;
               rsp_level_in = level_ff;
               rsp_exp_in   = exp_ff;
               rsp_swap_in  = 1'b0;
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in     = ST_OK;
                  st_wr.en          = 1'b1;
                  st_wr.addr        = {q_ff, tail_slot};
                  st_wr.data        = pid_ff;
                  ptr_wr.en         = 1'b1;
                  ptr_wr.addr       = q_ff;
                  ptr_wr.data.head  = ptr_rd.head;
                  ptr_wr.data.count = COUNT_W'(ptr_rd.count + 1'b1);
                  ne_in[q_ff]       = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               // get: read head id, advance head, drop count
               st_rd_en          = 1'b1;
               st_rd_addr        = {q_ff, ptr_rd.head};
               ptr_wr.en         = 1'b1;
               ptr_wr.addr       = q_ff;
               ptr_wr.data.head  = SLOT_W'(ptr_rd.head + 1'b1);
               ptr_wr.data.count = COUNT_W'(ptr_rd.count - 1'b1);
               if (ptr_rd.count == COUNT_W'(1)) begin
                  ne_in[q_ff] = 1'b0;
               end
               state_in = S_POP;
            end
         end
         S_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_pid_in    = st_rd;
            rsp_level_in  = level_ff;
            rsp_exp_in    = 1'b0;
            rsp_swap_in   = swap_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         act_ff        <= 1'b0;
         num_levels_ff <= NUM_LEVELS_RESET;
         ne_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         act_ff        <= act_in;
         num_levels_ff <= num_levels_in;
         ne_ff         <= ne_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      pid_ff        <= pid_in;
      q_ff          <= q_in;
      level_ff      <= level_in;
      exp_ff        <= exp_in;
      swap_ff       <= swap_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_swap_ff   <= rsp_swap_in;
   end

   // pointer table
   aeps_ptr_table u_ptr_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ptr_rd_en),
      .rd_addr (ptr_rd_addr),
      .rd_data (ptr_rd),
      .wr      (ptr_wr)
   );

   // id store
   aeps_id_store u_id_store (
      .clock   (clock),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd),
      .wr      (st_wr)
   );

   // result ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_proc_id       = rsp_pid_ff;
   assign rsp_level         = rsp_level_ff;
   assign rsp_to_expired    = rsp_exp_ff;
   assign rsp_banks_swapped = rsp_swap_ff;

   // occupancy vector and pointer table agree on a get
   `AEPS_ASSERT_NOW(a_get_nonempty, (state_ff == S_PTR) && mode_ff, ptr_rd.count != '0, "get popped an empty queue")
   // a get always goes through the id store read
   `AEPS_ASSERT_NEXT(a_get_to_pop, (state_ff == S_PTR) && mode_ff, state_ff == S_POP, "get skipped the id read")
   // a stored add marks its queue occupied
   `AEPS_ASSERT_NEXT(a_add_marks, (state_ff == S_PTR) && !mode_ff && !full, ne_ff[$past(q_ff)], "add left queue marked empty")
   // nothing-ready result carries no id, level or swap
   `AEPS_ASSERT_NOW(a_empty_fields, rsp_valid_ff && (rsp_status_ff == ST_EMPTY), (rsp_pid_ff == '0) && (rsp_level_ff == '0) && !rsp_swap_ff, "empty result fields not zero")

endmodule

`default_nettype wire

/* hw/rtl/aeps_ptr_table.sv */
// per-queue head pointer and fill count memory with reset valid bits
`timescale 1ns / 1ps
`default_nettype none

module aeps_ptr_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [aeps_pkg::QIDX_W-1:0] rd_addr,
   output aeps_pkg::ptr_entry_type          rd_data,
   input  wire aeps_pkg::ptr_wr_type        wr
);
   import aeps_pkg::*;

   ptr_entry_type             mem [NUM_QUEUES];
   logic [NUM_QUEUES-1:0]     valid_ff;
   logic [NUM_QUEUES-1:0]     valid_in;
   ptr_entry_type             rd_data_ff;
   logic                      rd_valid_ff;

   // valid bit set on first write, so never-written entries read as zero
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // memory array, registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* hw/rtl/aeps_id_store.sv */
// id storage of all level fifos, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module aeps_id_store (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [aeps_pkg::STORE_AW-1:0] rd_addr,
   output logic      [aeps_pkg::ID_W-1:0]     rd_data,
   input  wire aeps_pkg::store_wr_type        wr
);
   import aeps_pkg::*;

   logic [ID_W-1:0] mem [STORE_DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
